[rtl/clt_pkg.sv]
`timescale 1ns / 1ps

package clt_pkg;

    localparam int PENDING_SLOTS = 8;
    localparam int BUFFER_BYTES  = 4 * 1024;
    localparam int RING_W        = $clog2(PENDING_SLOTS);
    localparam int POS_W         = $clog2(BUFFER_BYTES);

    localparam int ARG_SLOTS     = 16;
    localparam int LEN_W         = 7;
    localparam int MAXLEN_W      = 6;
    localparam int MAXCNT_W      = 5;
    localparam int TOTAL_W       = 5;

    localparam logic [LEN_W-1:0]    LEN_SAT       = 7'd127;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET  = 6'd32;
    localparam logic [MAXCNT_W-1:0] MAXCNT_RESET  = 5'd16;
    localparam logic [MAXCNT_W-1:0] COUNT_CAP     = MAXCNT_W'(ARG_SLOTS);

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_TAB   = 8'd9;

    // configuration register indexes
    localparam logic REG_MAX_ARG_LENGTH = 1'b0;
    localparam logic REG_MAX_ARG_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_IN_ARG  = 2'd1,
        PH_BETWEEN = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [TOTAL_W-1:0]  arg_total;
        logic [LEN_W-1:0]    arg_length;
        logic                error_seen;
        logic [RING_W-1:0]   ring_slot;
        logic [POS_W-1:0]    buf_pos;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic        echo_newline;
        logic        arg_start;
        logic [3:0]  arg_slot;
        logic [11:0] arg_offset;
        logic        command_done;
        logic        command_error;
        logic [4:0]  command_args;
        logic [2:0]  command_slot;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

[rtl/clt_step.sv]
`timescale 1ns / 1ps

module clt_step (
    input  clt_pkg::parse_state_t          cur,
    input  logic [7:0]                     rx_byte,
    input  logic [clt_pkg::MAXLEN_W-1:0]   max_arg_length,
    input  logic [clt_pkg::MAXCNT_W-1:0]   max_arg_count,
    output clt_pkg::parse_state_t          nxt,
    output clt_pkg::result_t               res
);

    logic                          newline;
    logic                          too_long;
    logic [clt_pkg::MAXCNT_W-1:0]  limit;

    assign newline  = (rx_byte == clt_pkg::CH_LF) || (rx_byte == clt_pkg::CH_CR);
    assign too_long = cur.arg_length > {1'b0, max_arg_length};

    // clamp the count register to 1..16
    always_comb
    begin
        if (max_arg_count == '0)
            limit = clt_pkg::MAXCNT_W'(1);
        else if (max_arg_count > clt_pkg::COUNT_CAP)
            limit = clt_pkg::COUNT_CAP;
        else
            limit = max_arg_count;
    end

    always_comb
    begin
        nxt                = cur;
        res                = '0;
        res.echo_byte      = rx_byte;
        res.arg_offset     = 12'(cur.buf_pos);

        if (((cur.phase == clt_pkg::PH_IN_ARG) || (cur.phase == clt_pkg::PH_BETWEEN))
            && newline)
        begin
            nxt.error_seen     = cur.error_seen | too_long;
            res.echo_newline   = 1'b1;
            res.command_done   = 1'b1;
            res.command_error  = cur.error_seen | too_long;
            res.command_args   = cur.arg_total;
            res.command_slot   = 3'(cur.ring_slot);
            nxt.ring_slot      = (cur.ring_slot == clt_pkg::RING_W'(clt_pkg::PENDING_SLOTS - 1))
                                 ? '0 : cur.ring_slot + 1'b1;
            nxt.phase          = clt_pkg::PH_IDLE;
        end
        else
        begin
            unique case (cur.phase)
                clt_pkg::PH_IN_ARG:
                begin
                    if (rx_byte != clt_pkg::CH_SPACE)
                    begin
                        if (cur.arg_length < clt_pkg::LEN_SAT)
                            nxt.arg_length = cur.arg_length + 1'b1;
                    end
                    else
                    begin
                        nxt.error_seen = cur.error_seen | too_long;
                        nxt.phase      = clt_pkg::PH_BETWEEN;
                    end
                end
                clt_pkg::PH_BETWEEN:
                begin
                    if (rx_byte != clt_pkg::CH_SPACE)
                    begin
                        // drop a surplus argument and restart the slot count
                        if (cur.arg_total >= limit)
                        begin
                            nxt.error_seen = 1'b1;
                            nxt.arg_total  = '0;
                        end
                        else
                        begin
                            res.arg_start = 1'b1;
                            res.arg_slot  = cur.arg_total[3:0];
                            nxt.arg_total = cur.arg_total + 1'b1;
                        end
                        nxt.arg_length = clt_pkg::LEN_W'(1);
                        nxt.phase      = clt_pkg::PH_IN_ARG;
                    end
                end
                default:
                begin
                    if (!clt_pkg::is_ws(rx_byte))
                    begin
                        nxt.arg_total  = clt_pkg::TOTAL_W'(1);
                        res.arg_start  = 1'b1;
                        nxt.error_seen = 1'b0;
                        nxt.arg_length = clt_pkg::LEN_W'(1);
                        nxt.phase      = clt_pkg::PH_IN_ARG;
                    end
                end
            endcase
        end

        nxt.buf_pos = (cur.buf_pos == clt_pkg::POS_W'(clt_pkg::BUFFER_BYTES - 1))
                      ? '0 : cur.buf_pos + 1'b1;
    end

endmodule

[rtl/command_line_tokenizer.sv]
`timescale 1ns / 1ps
// Path: an accepted byte is held in the input register, then its result in the result register on the master side.
// Throughput: 1 byte per cycle while the master side accepts results; the parse state update is
// combinational logic between the input register and the result register.
// Reset: rst_n clears the parse state, ring slot, buffer position and both
// registers to their defaults (max_arg_length 32, max_arg_count 16).

module command_line_tokenizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // echo_byte[7:0], echo_newline[8], arg_start[9], arg_slot[13:10],
    // arg_offset[25:14], command_error[26], command_args[31:27],
    // command_slot[34:32], zero fill[39:35]
    output logic [39:0]                   m_axis_tdata,
    output logic                          m_axis_tlast,   // command_done
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [clt_pkg::MAXLEN_W-1:0]  cfg_wdata
);

    logic                          in_valid_reg, in_valid_next;
    logic [7:0]                    in_byte_reg;
    logic                          out_valid_reg, out_valid_next;
    clt_pkg::result_t              out_res_reg;
    clt_pkg::parse_state_t         state_reg, state_next;
    clt_pkg::result_t              res_next;
    logic [clt_pkg::MAXLEN_W-1:0]  max_len_reg;
    logic [clt_pkg::MAXCNT_W-1:0]  max_cnt_reg;
    logic                          advance;
    logic                          s_fire;
    logic                          work;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign work          = in_valid_reg && advance;

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    clt_step u_step (
        .cur            (state_reg),
        .rx_byte        (in_byte_reg),
        .max_arg_length (max_len_reg),
        .max_arg_count  (max_cnt_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: clt_pkg::PH_IDLE, default: '0};
            max_len_reg   <= clt_pkg::MAXLEN_RESET;
            max_cnt_reg   <= clt_pkg::MAXCNT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (work)
                state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == clt_pkg::REG_MAX_ARG_LENGTH)
                    max_len_reg <= cfg_wdata;
                else
                    max_cnt_reg <= cfg_wdata[clt_pkg::MAXCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_byte_reg <= s_axis_tdata;
        if (work)
            out_res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_res_reg.command_done;
    assign m_axis_tdata  = {5'b0,
                            out_res_reg.command_slot,
                            out_res_reg.command_args,
                            out_res_reg.command_error,
                            out_res_reg.arg_offset,
                            out_res_reg.arg_slot,
                            out_res_reg.arg_start,
                            out_res_reg.echo_newline,
                            out_res_reg.echo_byte};

endmodule

[rtl/clt_checker.sv]
`timescale 1ns / 1ps

module clt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tlast
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_done_newline: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[8])
        else $error("completed command without newline echo");

    a_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[13:10] == 4'd0)
        else $error("argument slot set without argument start");

    a_cmd_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            !m_axis_tdata[8] && !m_axis_tdata[26] &&
            m_axis_tdata[31:27] == 5'd0 && m_axis_tdata[34:32] == 3'd0)
        else $error("command fields set without command completion");

    a_args_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:27] <= 5'd16 && m_axis_tdata[39:35] == 5'd0)
        else $error("argument count or fill out of range");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/tb_command_line_tokenizer.sv]
`timescale 1ns / 1ps

module tb_command_line_tokenizer;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [39:0]                  m_axis_tdata;
    logic                         m_axis_tlast;
    logic                         cfg_we = 1'b0;
    logic                         cfg_index = clt_pkg::REG_MAX_ARG_LENGTH;
    logic [clt_pkg::MAXLEN_W-1:0] cfg_wdata = '0;

    // tokenizer state as predicted by the testbench
    clt_pkg::phase_t              tok_phase = clt_pkg::PH_IDLE;
    logic [clt_pkg::TOTAL_W-1:0]  tok_args = '0;
    logic [clt_pkg::LEN_W-1:0]    tok_len = '0;
    logic                         tok_err = 1'b0;
    logic [clt_pkg::RING_W-1:0]   tok_ring = '0;
    logic [clt_pkg::POS_W-1:0]    tok_pos = '0;
    logic [clt_pkg::MAXLEN_W-1:0] lim_len = clt_pkg::MAXLEN_RESET;
    logic [clt_pkg::MAXCNT_W-1:0] lim_cnt = clt_pkg::MAXCNT_RESET;

    clt_pkg::result_t             line_results[$];
    int                           mismatch_count = 0;
    int                           bytes_sent = 0;
    int                           burst_left = 0;
    logic [6:0]                   stall_phase = '0;

    command_line_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int arg_cap();
        if (lim_cnt == 0)
            return 1;
        if (lim_cnt > clt_pkg::ARG_SLOTS)
            return clt_pkg::ARG_SLOTS;
        return int'(lim_cnt);
    endfunction

    // Advance the predicted parse state by one received byte.
    function automatic clt_pkg::result_t tokenize_byte(input logic [7:0] c);
        clt_pkg::result_t r;
        r = '0;
        r.echo_byte  = c;
        r.arg_offset = tok_pos;
        if (tok_phase != clt_pkg::PH_IDLE && (c == clt_pkg::CH_LF || c == clt_pkg::CH_CR))
        begin
            if (tok_len > lim_len)
                tok_err = 1'b1;
            r.echo_newline  = 1'b1;
            r.command_done  = 1'b1;
            r.command_error = tok_err;
            r.command_args  = tok_args;
            r.command_slot  = tok_ring;
            tok_ring  = (tok_ring == clt_pkg::RING_W'(clt_pkg::PENDING_SLOTS - 1))
                        ? '0 : tok_ring + 1'b1;
            tok_phase = clt_pkg::PH_IDLE;
        end
        else if (tok_phase == clt_pkg::PH_IN_ARG)
        begin
            if (c != clt_pkg::CH_SPACE)
            begin
                if (tok_len < clt_pkg::LEN_SAT)
                    tok_len = tok_len + 1'b1;
            end
            else
            begin
                if (tok_len > lim_len)
                    tok_err = 1'b1;
                tok_phase = clt_pkg::PH_BETWEEN;
            end
        end
        else if (tok_phase == clt_pkg::PH_BETWEEN)
        begin
            if (c != clt_pkg::CH_SPACE)
            begin
                // surplus argument: flag it, restart the count, record nothing
                if (int'(tok_args) + 1 > arg_cap())
                begin
                    tok_err  = 1'b1;
                    tok_args = '0;
                end
                else
                begin
                    r.arg_start = 1'b1;
                    r.arg_slot  = tok_args[3:0];
                    tok_args    = tok_args + 1'b1;
                end
                tok_len   = 7'd1;
                tok_phase = clt_pkg::PH_IN_ARG;
            end
        end
        else if (!(c == clt_pkg::CH_SPACE || (c >= clt_pkg::CH_TAB && c <= clt_pkg::CH_CR)))
        begin
            tok_args    = 5'd1;
            r.arg_start = 1'b1;
            r.arg_slot  = '0;
            tok_err     = 1'b0;
            tok_len     = 7'd1;
            tok_phase   = clt_pkg::PH_IN_ARG;
        end
        tok_pos = (tok_pos == clt_pkg::POS_W'(clt_pkg::BUFFER_BYTES - 1)) ? '0 : tok_pos + 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want, input int unsigned pos);
        if (got !== want)
            report_mismatch($sformatf("offset %0d %s: got %0d, want %0d",
                                      pos, name, got, want));
    endtask

    // Sender: bursts of random length separated by random gaps.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(negedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        line_results.push_back(tokenize_byte(b));
        bytes_sent++;
        @(posedge clk);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (line_results.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [clt_pkg::MAXLEN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == clt_pkg::REG_MAX_ARG_LENGTH)
            lim_len = val;
        else
            lim_cnt = val[clt_pkg::MAXCNT_W-1:0];
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] arg_char();
        logic [7:0] c;
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom_range(33, 126));
        do
            c = 8'($urandom_range(0, 255));
        while (c == clt_pkg::CH_SPACE || c == clt_pkg::CH_LF || c == clt_pkg::CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] idle_char();
        if ($urandom_range(0, 3) == 0)
            return clt_pkg::CH_SPACE;
        return 8'($urandom_range(9, 13));
    endfunction

    task automatic send_random_line();
        int n_args;
        int len;
        // noise: arbitrary bytes, often leaving the parser mid-line
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) send_byte(idle_char());
        if ($urandom_range(0, 3) == 0)
            n_args = arg_cap() + $urandom_range(0, 2);
        else
            n_args = $urandom_range(1, (arg_cap() < 4) ? arg_cap() : 4);
        for (int a = 0; a < n_args; a++)
        begin
            if (a > 0)
                repeat ($urandom_range(1, 3)) send_byte(clt_pkg::CH_SPACE);
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(125, 135);
                1, 2:    len = int'(lim_len) + $urandom_range(0, 2);
                default: len = $urandom_range(1, 6);
            endcase
            if (len < 1)
                len = 1;
            repeat (len) send_byte(arg_char());
        end
        if ($urandom_range(0, 3) == 0)
            send_byte(clt_pkg::CH_SPACE);
        send_byte($urandom_range(0, 1) ? clt_pkg::CH_CR : clt_pkg::CH_LF);
    endtask

    task automatic test_idle_and_args();
        logic [7:0] seq[$];
        seq = '{8'd32, 8'd9, 8'd13, 8'd10, 8'd12, 8'h61, 8'd0, 8'd32, 8'd32, 8'd9,
                8'd255, 8'd32, 8'd128, 8'd13, 8'd10, 8'h7E, 8'd32, 8'd10};
        foreach (seq[i])
            send_byte(seq[i]);
        finish_phase();
    endtask

    task automatic test_length_limit();
        write_reg(clt_pkg::REG_MAX_ARG_LENGTH, 6'd1);
        send_string("ab c\n");
        finish_phase();
        // zero limit: every argument is too long
        write_reg(clt_pkg::REG_MAX_ARG_LENGTH, 6'd0);
        send_string("z\r");
        finish_phase();
        write_reg(clt_pkg::REG_MAX_ARG_LENGTH, 6'd63);
    endtask

    task automatic test_count_limit();
        write_reg(clt_pkg::REG_MAX_ARG_COUNT, 6'd1);
        send_string("a b c\n");
        finish_phase();
        write_reg(clt_pkg::REG_MAX_ARG_COUNT, 6'd16);
    endtask

    task automatic test_random_lines();
        int len_tab[7] = '{32, 63, 1, 0, 7, 20, 63};
        int cnt_tab[7] = '{16, 16, 1, 0, 31, 3, 17};
        int first;
        for (int p = 0; p < 9; p++)
        begin
            if (p < 7)
            begin
                write_reg(clt_pkg::REG_MAX_ARG_LENGTH, 6'(len_tab[p]));
                write_reg(clt_pkg::REG_MAX_ARG_COUNT, 6'(cnt_tab[p]));
            end
            else
            begin
                write_reg(clt_pkg::REG_MAX_ARG_LENGTH, 6'($urandom_range(1, 63)));
                write_reg(clt_pkg::REG_MAX_ARG_COUNT, 6'($urandom_range(1, 16)));
            end
            first = bytes_sent;
            while (bytes_sent - first < 145)
                send_random_line();
            finish_phase();
        end
    endtask

    // Receiver stall pattern: ready, coin flip, mostly stalled, mostly ready.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[6:5])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 1) == 1);
            2'd2:    m_axis_tready <= (stall_phase[1:0] == 2'd3);
            default: m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // Outputs are stable between edges; sample the request at the falling edge.
    always @(negedge clk)
    begin : check_results
        clt_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (line_results.size() == 0)
                report_mismatch($sformatf("result with nothing pending, tdata=%h",
                                          m_axis_tdata));
            else
            begin
                want = line_results.pop_front();
                check_field("echo_byte", m_axis_tdata[7:0], want.echo_byte,
                            want.arg_offset);
                check_field("echo_newline", m_axis_tdata[8], want.echo_newline,
                            want.arg_offset);
                check_field("arg_start", m_axis_tdata[9], want.arg_start,
                            want.arg_offset);
                check_field("arg_slot", m_axis_tdata[13:10], want.arg_slot,
                            want.arg_offset);
                check_field("arg_offset", m_axis_tdata[25:14], want.arg_offset,
                            want.arg_offset);
                check_field("command_done", m_axis_tlast, want.command_done,
                            want.arg_offset);
                check_field("command_error", m_axis_tdata[26], want.command_error,
                            want.arg_offset);
                check_field("command_args", m_axis_tdata[31:27], want.command_args,
                            want.arg_offset);
                check_field("command_slot", m_axis_tdata[34:32], want.command_slot,
                            want.arg_offset);
                check_field("zero fill", m_axis_tdata[39:35], 0, want.arg_offset);
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_args();
        test_length_limit();
        test_count_limit();
        test_random_lines();
        finish_phase();
        repeat (8) @(posedge clk);
        if (line_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", line_results.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
